// ===== sv/lpm_pkg.sv =====
// lpm_pkg: shared types and constants of the luma PSNR meter.
// Depends on nothing; used by every module of the block but lpm_queue.
package lpm_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;
    localparam int unsigned LOG_BITS_DEF   = 8;

    // Fixed arithmetic constants
    localparam logic [15:0] PEAK_SQ         = 16'd65025;
    localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
    localparam logic [14:0] PSNR_MAX        = 15'd32767;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT  = 2'd2;

    typedef struct packed {
        logic [7:0] ref_sample;
        logic [7:0] test_sample;
    } t_sample_pair;

    typedef struct packed {
        logic [14:0] frame_psnr;
        logic        frame_identical;
        logic [14:0] sequence_psnr;
        logic        sequence_done;
    } t_psnr_result;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] frame_count;
    } t_cfg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM,
        BK_SQR,
        BK_SCALE,
        BK_ROUND,
        BK_ACC,
        BK_DIV,
        BK_WRITE
    } t_back_state;

endpackage

// ===== sv/luma_psnr_meter.sv =====
// luma_psnr_meter: top level of the frame and sequence luma PSNR meter.
// Depends on lpm_pkg, lpm_queue, lpm_front and lpm_back.
//
// Input channel: a beat is one pair of co-located 8-bit luma samples,
// taken when i_push is high and o_full is low; up to one beat per cycle.
// Result channel: one result per closed frame with the frame PSNR in Q7.8
// dB, an identical-frame flag and, on the last frame of a sequence, the
// rounded mean PSNR and a done flag. A result is shown while o_empty is low
// and leaves when i_pop is high.
// Configuration: i_cfg_we writes register i_cfg_idx (0 width, 1 height,
// 2 frame count) at once; write only while the block is idle.
// Computation: after a frame's last beat, the back part runs two normalize
// walks (first on the pixel count times 255^2, then on the SSE) with
// LOG_TABLE_BITS squarings each, then scaling, rounding, the sum, a
// restoring division with 32 quotient bits for the mean and the result
// write. A frame that is not the last of its sequence skips the division;
// an identical frame skips the log2 walks. Sample beats keep flowing during
// that time: a two-entry frame-job queue holds closed frames, and o_full
// rises only when it is full, i.e. frames shorter than the computation time.
// Reset (synchronous, active low) clears all sums, counters and queues and
// loads 1920 x 1080, one frame per sequence. When the receiver stalls, two
// results are held; then the job queue fills and o_full rises.
module luma_psnr_meter #(
    parameter int unsigned MAX_WIDTH      = lpm_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT     = lpm_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned LOG_TABLE_BITS = lpm_pkg::LOG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  lpm_pkg::t_sample_pair i_pair,
    output logic                  o_empty,
    input  logic                  i_pop,
    output lpm_pkg::t_psnr_result o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    localparam int unsigned CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int unsigned XW    = CNT_W + 16;
    localparam int unsigned JW    = CNT_W + XW;
    localparam int unsigned RW    = $bits(lpm_pkg::t_psnr_result);

    lpm_pkg::t_cfg         r_cfg;
    logic                  w_job_push, w_job_pop, w_job_full, w_job_empty;
    logic [CNT_W-1:0]      w_fr_pixels;
    logic [XW-1:0]         w_fr_sse;
    logic [JW-1:0]         w_job_q;
    logic                  w_res_push, w_res_full;
    lpm_pkg::t_psnr_result w_res;
    logic [RW-1:0]         w_res_q;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= 13'd1920;
            r_cfg.frame_height <= 13'd1080;
            r_cfg.frame_count  <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpm_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[12:0];
                lpm_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[12:0];
                lpm_pkg::REG_FRAME_COUNT:  r_cfg.frame_count  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lpm_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CNT_W(CNT_W), .XW(XW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_pair(i_pair),
        .i_cfg(r_cfg), .i_job_full(w_job_full), .o_full(o_full),
        .o_job_push(w_job_push), .o_job_pixels(w_fr_pixels), .o_job_sse(w_fr_sse)
    );

    // frame jobs between front and back
    lpm_queue #(.WIDTH(JW), .DEPTH(2)) u_job_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_job_push),
        .i_data({w_fr_pixels, w_fr_sse}), .i_pop(w_job_pop), .o_data(w_job_q),
        .o_full(w_job_full), .o_empty(w_job_empty)
    );

    lpm_back #(.CNT_W(CNT_W), .XW(XW), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_job_empty(w_job_empty), .i_job_pixels(w_job_q[JW-1 -: CNT_W]),
        .i_job_sse(w_job_q[XW-1:0]), .o_job_pop(w_job_pop),
        .i_res_full(w_res_full), .o_res_push(w_res_push), .o_res(w_res)
    );

    // result queue toward the receiver
    lpm_queue #(.WIDTH(RW), .DEPTH(2)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_res_push), .i_data(w_res),
        .i_pop(i_pop), .o_data(w_res_q), .o_full(w_res_full), .o_empty(o_empty)
    );

    assign o_result = w_res_q;
endmodule

// ===== sv/lpm_queue.sv =====
// lpm_queue: small first-in first-out buffer of fixed-width words.
// Depends on nothing; used between front and back and on the result side.
module lpm_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== sv/lpm_front.sv =====
// lpm_front: takes sample beats, accumulates SSE and counts pixels of a frame.
// Depends on lpm_pkg; hands one frame job per closed frame to the back part.
module lpm_front #(
    parameter int unsigned MAX_WIDTH  = lpm_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = lpm_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int unsigned XW         = CNT_W + 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lpm_pkg::t_sample_pair i_pair,
    input  lpm_pkg::t_cfg        i_cfg,
    input  logic                 i_job_full,
    output logic                 o_full,
    output logic                 o_job_push,
    output logic [CNT_W-1:0]     o_job_pixels,
    output logic [XW-1:0]        o_job_sse
);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

    logic [XW-1:0]    r_sse, n_sse;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WW-1:0]    w_w;
    logic [HW-1:0]    w_h;
    logic [CNT_W-1:0] w_size;
    logic [7:0]       w_d;
    logic             w_take, w_close;

    assign o_full = i_job_full;
    assign w_take = i_push && !i_job_full;

    // clamp the frame size registers
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_w = WW'(1);
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            w_h = HW'(1);
        end else if (32'(i_cfg.frame_height) > MAX_HEIGHT) begin
            w_h = HW'(MAX_HEIGHT);
        end else begin
            w_h = HW'(i_cfg.frame_height);
        end
        w_size = CNT_W'(CNT_W'(w_w) * CNT_W'(w_h));
    end

    // squared difference and frame close
    always_comb begin
        w_d     = (i_pair.ref_sample > i_pair.test_sample) ?
                  i_pair.ref_sample - i_pair.test_sample :
                  i_pair.test_sample - i_pair.ref_sample;
        n_sse   = r_sse + XW'(16'(w_d) * 16'(w_d));
        n_cnt   = r_cnt + 1'b1;
        w_close = (n_cnt >= w_size);
    end

    assign o_job_push   = w_take && w_close;
    assign o_job_pixels = n_cnt;
    assign o_job_sse    = n_sse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sse <= '0;
            r_cnt <= '0;
        end else if (w_take) begin
            r_sse <= w_close ? '0 : n_sse;
            r_cnt <= w_close ? '0 : n_cnt;
        end
    end
endmodule

// ===== sv/lpm_back.sv =====
// lpm_back: per-frame PSNR from a frame job: shared log2 unit, scaling,
// sequence sum and mean by restoring division. Depends on lpm_pkg.
module lpm_back #(
    parameter int unsigned CNT_W          = 25,
    parameter int unsigned XW             = CNT_W + 16,
    parameter int unsigned LOG_TABLE_BITS = lpm_pkg::LOG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpm_pkg::t_cfg         i_cfg,
    input  logic                  i_job_empty,
    input  logic [CNT_W-1:0]      i_job_pixels,
    input  logic [XW-1:0]         i_job_sse,
    output logic                  o_job_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output lpm_pkg::t_psnr_result o_res
);
    localparam int unsigned LTB = LOG_TABLE_BITS;
    localparam int unsigned EW  = $clog2(XW);
    localparam int unsigned LW  = EW + LTB;
    localparam int unsigned VW  = LW + 18;
    localparam int unsigned KW  = $clog2(LTB);

    lpm_pkg::t_back_state r_state, n_state;
    logic [XW-1:0]  r_x, n_x, r_sse, n_sse;
    logic [EW-1:0]  r_e, n_e;
    logic [30:0]    r_m, n_m;
    logic [LTB-1:0] r_frac, n_frac;
    logic [KW-1:0]  r_k, n_k;
    logic           r_pass, n_pass;
    logic [LW-1:0]  r_ln, n_ln;
    logic [VW-1:0]  r_v, n_v;
    logic [14:0]    r_db, n_db;
    logic           r_same, n_same;
    logic [30:0]    r_sum, n_sum;
    logic [15:0]    r_frames, n_frames;
    logic [31:0]    r_q, n_q;
    logic [15:0]    r_rem, n_rem;
    logic [15:0]    r_div, n_div;
    logic [4:0]     r_dk, n_dk;
    logic           r_seq_done, n_seq_done;
    logic [14:0]    r_seq_psnr, n_seq_psnr;

    logic [61:0]    w_sq;
    logic [31:0]    w_t;
    logic [LW-1:0]  w_ld;
    logic [VW:0]    w_round;
    logic [VW:0]    w_sh;
    logic [16:0]    w_rem2;
    logic [15:0]    w_fc;
    logic [30:0]    w_sum;
    logic [15:0]    w_frames;

    assign w_sq    = 62'(r_m) * 62'(r_m);
    assign w_t     = w_sq[61:30];
    assign w_ld    = {r_e, r_frac};
    assign w_round = (VW + 1)'(r_v) + ((VW + 1)'(1) << (LTB + 7));
    assign w_sh    = w_round >> (LTB + 8);
    assign w_rem2  = {r_rem, r_q[31]};
    assign w_fc    = (i_cfg.frame_count == '0) ? 16'd1 : i_cfg.frame_count;
    assign w_sum   = r_sum + 31'(r_db);
    assign w_frames = r_frames + 1'b1;

    assign o_res.frame_psnr      = r_db;
    assign o_res.frame_identical = r_same;
    assign o_res.sequence_psnr   = r_seq_psnr;
    assign o_res.sequence_done   = r_seq_done;

    // sequencer: next state and datapath updates
    always_comb begin
        n_state = r_state;   n_x = r_x;         n_sse = r_sse;
        n_e = r_e;           n_m = r_m;         n_frac = r_frac;
        n_k = r_k;           n_pass = r_pass;   n_ln = r_ln;
        n_v = r_v;           n_db = r_db;       n_same = r_same;
        n_sum = r_sum;       n_frames = r_frames;
        n_q = r_q;           n_rem = r_rem;     n_div = r_div;
        n_dk = r_dk;         n_seq_done = r_seq_done;
        n_seq_psnr = r_seq_psnr;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            lpm_pkg::BK_IDLE: begin
                if (!i_job_empty && !i_res_full) begin
                    o_job_pop = 1'b1;
                    n_sse  = i_job_sse;
                    n_x    = XW'(i_job_pixels) * XW'(lpm_pkg::PEAK_SQ);
                    n_e    = EW'(XW - 1);
                    n_pass = 1'b0;
                    if (i_job_sse == '0) begin
                        n_db    = lpm_pkg::PSNR_MAX;
                        n_same  = 1'b1;
                        n_state = lpm_pkg::BK_ACC;
                    end else begin
                        n_same  = 1'b0;
                        n_state = lpm_pkg::BK_NORM;
                    end
                end
            end
            // normalize: one bit position a beat
            lpm_pkg::BK_NORM: begin
                if (r_x[XW-1]) begin
                    n_m     = r_x[XW-1 -: 31];
                    n_k     = '0;
                    n_frac  = '0;
                    n_state = lpm_pkg::BK_SQR;
                end else begin
                    n_x = r_x << 1;
                    n_e = r_e - 1'b1;
                end
            end
            // one fraction bit per squaring
            lpm_pkg::BK_SQR: begin
                n_m    = w_t[31] ? w_t[31:1] : w_t[30:0];
                n_frac = {r_frac[LTB-2:0], w_t[31]};
                n_k    = r_k + 1'b1;
                if (r_k == KW'(LTB - 1)) begin
                    if (!r_pass) begin
                        n_ln    = {r_e, r_frac[LTB-2:0], w_t[31]};
                        n_x     = r_sse;
                        n_e     = EW'(XW - 1);
                        n_pass  = 1'b1;
                        n_state = lpm_pkg::BK_NORM;
                    end else begin
                        n_state = lpm_pkg::BK_SCALE;
                    end
                end
            end
            lpm_pkg::BK_SCALE: begin
                if (r_ln <= w_ld) begin
                    n_db    = '0;
                    n_state = lpm_pkg::BK_ACC;
                end else begin
                    n_v     = VW'(r_ln - w_ld) * VW'(lpm_pkg::TEN_LOG10_2_Q16);
                    n_state = lpm_pkg::BK_ROUND;
                end
            end
            lpm_pkg::BK_ROUND: begin
                n_db    = (w_sh > (VW + 1)'(lpm_pkg::PSNR_MAX)) ?
                          lpm_pkg::PSNR_MAX : w_sh[14:0];
                n_state = lpm_pkg::BK_ACC;
            end
            // sequence sum; start the mean when the sequence closes
            lpm_pkg::BK_ACC: begin
                if (w_frames >= w_fc) begin
                    n_q        = 32'(w_sum) + 32'(w_frames >> 1);
                    n_rem      = '0;
                    n_div      = w_frames;
                    n_dk       = '0;
                    n_sum      = '0;
                    n_frames   = '0;
                    n_seq_done = 1'b1;
                    n_state    = lpm_pkg::BK_DIV;
                end else begin
                    n_sum      = w_sum;
                    n_frames   = w_frames;
                    n_seq_done = 1'b0;
                    n_seq_psnr = '0;
                    n_state    = lpm_pkg::BK_WRITE;
                end
            end
            // restoring division, one quotient bit a beat
            lpm_pkg::BK_DIV: begin
                if (w_rem2 >= 17'(r_div)) begin
                    n_rem = 16'(w_rem2 - 17'(r_div));
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_rem = w_rem2[15:0];
                    n_q   = {r_q[30:0], 1'b0};
                end
                n_dk = r_dk + 1'b1;
                if (r_dk == 5'd31) begin
                    n_seq_psnr = (n_q > 32'(lpm_pkg::PSNR_MAX)) ?
                                 lpm_pkg::PSNR_MAX : n_q[14:0];
                    n_state    = lpm_pkg::BK_WRITE;
                end
            end
            lpm_pkg::BK_WRITE: begin
                o_res_push = 1'b1;
                n_state    = lpm_pkg::BK_IDLE;
            end
            default: begin
                n_state = lpm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lpm_pkg::BK_IDLE;
            r_sum    <= '0;
            r_frames <= '0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_frames <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;         r_sse <= n_sse;     r_e <= n_e;
        r_m <= n_m;         r_frac <= n_frac;   r_k <= n_k;
        r_pass <= n_pass;   r_ln <= n_ln;       r_v <= n_v;
        r_db <= n_db;       r_same <= n_same;   r_q <= n_q;
        r_rem <= n_rem;     r_div <= n_div;     r_dk <= n_dk;
        r_seq_done <= n_seq_done;
        r_seq_psnr <= n_seq_psnr;
    end

    // mantissa stays in [1, 2) while squaring
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpm_pkg::BK_SQR) |-> r_m[30])
        else $error("log mantissa lost normalization");

    // a result is only written into a queue with room
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result written into full queue");

    // a taken job always leaves idle
    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state != lpm_pkg::BK_IDLE))
        else $error("job popped but sequencer stayed idle");

    // a job is only taken from idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == lpm_pkg::BK_IDLE) && !i_job_empty)
        else $error("job popped outside idle");
endmodule
